// ===== sv/line_rasterizer_defines.svh =====
// Assertion macros for the line rasterizer checker.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define LR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("line_rasterizer: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define LR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("line_rasterizer: next-cycle check failed");

`endif

// ===== sv/lr_pkg.sv =====
// Shared types and constants of the line rasterizer.
package lr_pkg;

    localparam int COORD_W = 6;

    typedef logic [COORD_W-1:0] coord_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture a new line command
        logic step;   // emit the current pixel and advance
    } lr_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;  // output register can take a pixel this cycle
        logic at_end;    // current pixel is the end endpoint
    } lr_status_t;

endpackage

// ===== sv/lr_datapath.sv =====
// Line rasterizer datapath: endpoint setup, incremental stepping, output register.
module lr_datapath #(
    parameter int GRID_SIZE = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lr_pkg::lr_cmd_t    cmd,
    output lr_pkg::lr_status_t status,
    input  lr_pkg::coord_t     start_x,
    input  lr_pkg::coord_t     start_y,
    input  lr_pkg::coord_t     end_x,
    input  lr_pkg::coord_t     end_y,
    output logic               out_valid,
    input  logic               out_ready,
    output lr_pkg::coord_t     pixel_x,
    output lr_pkg::coord_t     pixel_y,
    output logic               last_pixel
);
    import lr_pkg::*;

    localparam int MaxCoordInt = (GRID_SIZE > (1 << COORD_W)) ? ((1 << COORD_W) - 1)
                                                              : (GRID_SIZE - 1);
    localparam coord_t MAX_COORD = COORD_W'(MaxCoordInt);

    coord_t x0, y0, x1, y1;
    coord_t adx, ady, n_val, d_val;
    logic   x_neg, y_neg, x_major;

    coord_t              cur_x_reg, cur_y_reg;
    coord_t              n_reg, k_reg;
    logic [COORD_W:0]    n2_reg, d2_reg;
    logic signed [COORD_W+2:0] err_reg;
    logic                x_major_reg, major_neg_reg, minor_neg_reg;

    logic signed [COORD_W+2:0] err_sum, err_next, n2_s, d2_s;
    logic   minor_up, minor_down;
    coord_t major_cur, minor_cur, major_next, minor_next;

    logic   out_valid_reg;
    coord_t pixel_x_reg, pixel_y_reg;
    logic   last_reg;

    // Saturate endpoints to the grid.
    assign x0 = (start_x > MAX_COORD) ? MAX_COORD : start_x;
    assign y0 = (start_y > MAX_COORD) ? MAX_COORD : start_y;
    assign x1 = (end_x > MAX_COORD) ? MAX_COORD : end_x;
    assign y1 = (end_y > MAX_COORD) ? MAX_COORD : end_y;

    assign x_neg   = x1 < x0;
    assign y_neg   = y1 < y0;
    assign adx     = x_neg ? (x0 - x1) : (x1 - x0);
    assign ady     = y_neg ? (y0 - y1) : (y1 - y0);
    assign x_major = adx >= ady;
    assign n_val   = x_major ? adx : ady;
    assign d_val   = x_major ? ady : adx;

    // Error term r: minor offset q satisfies 2*d*k + n = q*2n + r, 0 <= r < 2n.
    assign n2_s    = $signed({2'b00, n2_reg});
    assign d2_s    = $signed({2'b00, d2_reg});
    assign err_sum = minor_neg_reg ? (err_reg - d2_s) : (err_reg + d2_s);
    assign minor_up   = !minor_neg_reg && (err_sum >= n2_s);
    assign minor_down = minor_neg_reg && (err_sum < 0);

    always_comb begin
        err_next = err_sum;
        if (minor_up) begin
            err_next = err_sum - n2_s;
        end else if (minor_down) begin
            err_next = err_sum + n2_s;
        end
    end

    assign major_cur  = x_major_reg ? cur_x_reg : cur_y_reg;
    assign minor_cur  = x_major_reg ? cur_y_reg : cur_x_reg;
    assign major_next = major_neg_reg ? (major_cur - 1'b1) : (major_cur + 1'b1);
    assign minor_next = minor_up ? (minor_cur + 1'b1)
                      : (minor_down ? (minor_cur - 1'b1) : minor_cur);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_x_reg     <= x0;
            cur_y_reg     <= y0;
            n_reg         <= n_val;
            k_reg         <= '0;
            n2_reg        <= {n_val, 1'b0};
            d2_reg        <= {d_val, 1'b0};
            err_reg       <= $signed({3'b000, n_val});
            x_major_reg   <= x_major;
            major_neg_reg <= x_major ? x_neg : y_neg;
            minor_neg_reg <= x_major ? y_neg : x_neg;
        end else if (cmd.step) begin
            k_reg   <= k_reg + 1'b1;
            err_reg <= err_next;
            if (x_major_reg) begin
                cur_x_reg <= major_next;
                cur_y_reg <= minor_next;
            end else begin
                cur_y_reg <= major_next;
                cur_x_reg <= minor_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            pixel_x_reg <= cur_x_reg;
            pixel_y_reg <= cur_y_reg;
            last_reg    <= (k_reg == n_reg);
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.at_end   = (k_reg == n_reg);

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_reg;

endmodule

// ===== sv/lr_ctrl.sv =====
// Line rasterizer controller: command intake and per-pixel stepping.
module lr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lr_pkg::lr_status_t status,
    output lr_pkg::lr_cmd_t    cmd
);
    import lr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_comb begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd.load = in_valid;
            ST_RUN:  cmd.step = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_RUN;
                        ready_reg <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (status.out_free && status.at_end) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready = ready_reg;

endmodule

// ===== sv/line_rasterizer.sv =====
// Line rasterizer top level: controller plus stepping datapath.
//
// Input channel s_*: one line command (start and end endpoint) per item.
// Output channel m_*: one pixel per item, start endpoint first, end
// endpoint last with m_last_pixel set; max(|dx|,|dy|)+1 items per line.
// Timing: an accepted command is loaded into the stepping registers, then
// the first pixel enters the output register and m_valid rises. The
// single stepping unit then advances one pixel per cycle while m_ready is
// high; lines are handled one at a time, and the major delta n is up to
// 63. The next command is taken once the end pixel has entered the
// output register, while that pixel still waits there.
// Stall: with m_ready low the output register holds its pixel and the
// stepping unit waits; nothing is lost.
// Reset (aresetn low, synchronous): the output empties and the block
// returns to waiting for a command.
module line_rasterizer #(
    parameter int GRID_SIZE = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lr_pkg::coord_t s_start_x,
    input  lr_pkg::coord_t s_start_y,
    input  lr_pkg::coord_t s_end_x,
    input  lr_pkg::coord_t s_end_y,
    output logic           m_valid,
    input  logic           m_ready,
    output lr_pkg::coord_t m_pixel_x,
    output lr_pkg::coord_t m_pixel_y,
    output logic           m_last_pixel
);
    import lr_pkg::*;

    lr_cmd_t    cmd;
    lr_status_t status;

    lr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lr_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .start_x    (s_start_x),
        .start_y    (s_start_y),
        .end_x      (s_end_x),
        .end_y      (s_end_y),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .pixel_x    (m_pixel_x),
        .pixel_y    (m_pixel_y),
        .last_pixel (m_last_pixel)
    );

endmodule

// ===== sv/lr_checker.sv =====
// Port-level checker for the line rasterizer, bound to the top level.
`include "line_rasterizer_defines.svh"

module lr_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input lr_pkg::coord_t s_start_x,
    input lr_pkg::coord_t s_start_y,
    input lr_pkg::coord_t s_end_x,
    input lr_pkg::coord_t s_end_y,
    input logic           m_valid,
    input logic           m_ready,
    input lr_pkg::coord_t m_pixel_x,
    input lr_pkg::coord_t m_pixel_y,
    input logic           m_last_pixel
);
    import lr_pkg::*;

    logic s_fire;
    logic m_stall;
    logic [4*COORD_W-1:0] s_cmd_bits;

    assign s_fire     = s_valid && s_ready;
    assign m_stall    = m_valid && !m_ready;
    assign s_cmd_bits = {s_start_x, s_start_y, s_end_x, s_end_y};

    // A stalled pixel holds.
    `LR_ASSERT_NEXT(a_out_hold, m_stall,
        m_valid && $stable(m_pixel_x) && $stable(m_pixel_y) && $stable(m_last_pixel))

    // A waiting command holds.
    `LR_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_cmd_bits))

    // One line at a time.
    `LR_ASSERT_NEXT(a_one_cmd, s_fire, !s_ready)

    // A new command is taken only once the previous line's end pixel is out.
    `LR_ASSERT_NOW(a_ready_after_end, s_ready, !m_valid || m_last_pixel)

    // The setup cycle after a command emits nothing new.
    `LR_ASSERT_NEXT(a_setup_quiet, s_fire, !m_valid || m_last_pixel)

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for line_rasterizer: directed and random lines, pixel predictor.
`timescale 1ns / 100ps

module tb_top;
    import lr_pkg::*;

    localparam int GRID         = 64;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int N_RANDOM     = 258;
    localparam int SETTLE       = 80;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int N_DIRECTED   = 22;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        logic   known;
        coord_t kx;
        coord_t ky;
    } line_cmd_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    // start x, start y, end x, end y, known single pixel, its x, its y
    localparam int DIRECTED [N_DIRECTED][7] = '{
        '{ 0,  0,  0,  0, 1,  0,  0},
        '{63, 63, 63, 63, 1, 63, 63},
        '{ 0, 63,  0, 63, 1,  0, 63},
        '{63,  0, 63,  0, 1, 63,  0},
        '{21, 42, 21, 42, 1, 21, 42},
        '{ 0,  0, 63,  0, 0,  0,  0},
        '{63, 63,  0, 63, 0,  0,  0},
        '{ 0,  0,  0, 63, 0,  0,  0},
        '{63, 63, 63,  0, 0,  0,  0},
        '{ 0,  0, 63, 63, 0,  0,  0},
        '{63,  0,  0, 63, 0,  0,  0},
        '{63, 63,  0,  0, 0,  0,  0},
        '{ 0,  0,  2,  1, 0,  0,  0},
        '{ 0,  1,  2,  0, 0,  0,  0},
        '{ 0,  0,  1,  2, 0,  0,  0},
        '{ 1,  0,  0,  2, 0,  0,  0},
        '{ 5,  5,  6,  6, 0,  0,  0},
        '{ 0,  0, 63,  1, 0,  0,  0},
        '{ 0, 63, 63,  0, 0,  0,  0},
        '{10,  0, 11, 63, 0,  0,  0},
        '{42, 21, 21, 42, 0,  0,  0},
        '{63,  0,  0,  1, 0,  0,  0}
    };

    logic   aclk      = 1'b0;
    logic   aresetn   = 1'b0;
    logic   s_valid   = 1'b0;
    logic   s_ready;
    coord_t s_start_x = '0;
    coord_t s_start_y = '0;
    coord_t s_end_x   = '0;
    coord_t s_end_y   = '0;
    logic   m_valid;
    logic   m_ready   = 1'b0;
    coord_t m_pixel_x;
    coord_t m_pixel_y;
    logic   m_last_pixel;

    pixel_t pixel_q[$];
    int     err_count = 0;
    int     n_lines   = 0;
    int     n_pixels  = 0;
    bit     steady    = 1'b0;

    line_rasterizer #(
        .GRID_SIZE(GRID)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_last_pixel (m_last_pixel)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int idle_cycles();
        return steady ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic int div_floor(int num, int den);
        int q;
        q = num / den;
        if (num % den != 0 && num < 0) q--;
        return q;
    endfunction

    function automatic int to_grid(coord_t c);
        return (int'(c) > GRID - 1) ? GRID - 1 : int'(c);
    endfunction

    function automatic int fit(int v);
        return (v < 0) ? 0 : ((v > 63) ? 63 : v);
    endfunction

    // pixels of one line, minor axis rounded half up
    function automatic void rasterize_line(line_cmd_t c);
        int     x0, y0, dx, dy, adx, ady, n, px, py;
        bit     x_major;
        pixel_t p;
        x0      = to_grid(c.x0);
        y0      = to_grid(c.y0);
        dx      = to_grid(c.x1) - x0;
        dy      = to_grid(c.y1) - y0;
        adx     = dx < 0 ? -dx : dx;
        ady     = dy < 0 ? -dy : dy;
        x_major = adx >= ady;
        n       = x_major ? adx : ady;
        for (int k = 0; k <= n; k++) begin
            if (n == 0) begin
                px = x0;
                py = y0;
            end else if (x_major) begin
                px = x0 + (dx < 0 ? -k : k);
                py = y0 + div_floor(2 * dy * k + n, 2 * n);
            end else begin
                py = y0 + (dy < 0 ? -k : k);
                px = x0 + div_floor(2 * dx * k + n, 2 * n);
            end
            p.x    = coord_t'(px);
            p.y    = coord_t'(py);
            p.last = (k == n);
            pixel_q.push_back(p);
        end
    endfunction

    function automatic line_cmd_t random_line();
        line_cmd_t c;
        int        x0, y0, x1, y1, d, kind, off;
        x0   = $urandom_range(0, 63);
        y0   = $urandom_range(0, 63);
        x1   = $urandom_range(0, 63);
        y1   = $urandom_range(0, 63);
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                x1 = x0;
                y1 = y0;
            end
            1: y1 = y0;
            2: x1 = x0;
            3: begin
                d  = (x1 > x0) ? x1 - x0 : x0 - x1;
                y0 = $urandom_range(0, 63 - d);
                y1 = y0 + d;
                if ($urandom_range(0, 1)) begin
                    y1 = y0;
                    y0 = y0 + d;
                end
            end
            4, 5: begin
                off = $urandom_range(0, 8);
                x1  = fit(x0 + off - 4);
                off = $urandom_range(0, 8);
                y1  = fit(y0 + off - 4);
            end
            default: ;
        endcase
        c.x0    = coord_t'(x0);
        c.y0    = coord_t'(y0);
        c.x1    = coord_t'(x1);
        c.y1    = coord_t'(y1);
        c.known = 1'b0;
        c.kx    = '0;
        c.ky    = '0;
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < 40) $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_line(line_cmd_t c);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_start_x <= c.x0;
        s_start_y <= c.y0;
        s_end_x   <= c.x1;
        s_end_y   <= c.y1;
        do @(posedge aclk); while (!s_ready);
        n_lines++;
        if (c.known) pixel_q.push_back('{c.kx, c.ky, 1'b1});
        else rasterize_line(c);
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            n_pixels++;
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                          m_pixel_x, m_pixel_y, m_last_pixel));
            end else begin
                want = pixel_q.pop_front();
                if (m_pixel_x !== want.x)
                    report_mismatch($sformatf("pixel_x %0d, want %0d", m_pixel_x, want.x));
                if (m_pixel_y !== want.y)
                    report_mismatch($sformatf("pixel_y %0d, want %0d", m_pixel_y, want.y));
                if (m_last_pixel !== want.last)
                    report_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                              m_last_pixel, want.last, want.x, want.y));
            end
        end
    end

    initial begin
        line_cmd_t c;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            c.x0    = coord_t'(DIRECTED[i][0]);
            c.y0    = coord_t'(DIRECTED[i][1]);
            c.x1    = coord_t'(DIRECTED[i][2]);
            c.y1    = coord_t'(DIRECTED[i][3]);
            c.known = DIRECTED[i][4] != 0;
            c.kx    = coord_t'(DIRECTED[i][5]);
            c.ky    = coord_t'(DIRECTED[i][6]);
            send_line(c);
        end

        // hold off until the output has drained completely
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            steady = ((i / 40) % 3 == 1);
            send_line(random_line());
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Ran %0d lines (%0d pixels): endpoints, axis-aligned, diagonal, ties, random.",
                 n_lines, n_pixels);
        $display("Sender gaps and receiver stalls of 0 to 3 cycles, with stall-free stretches.");
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timeout after %0d ns", LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== line_rasterizer.f =====
+incdir+sv
sv/lr_pkg.sv
sv/lr_datapath.sv
sv/lr_ctrl.sv
sv/line_rasterizer.sv
sv/lr_checker.sv
dv/tb_top.sv
